### design/sli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants for the sorted list insert/delete store.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } mode_e;

  // One input beat.
  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         occupancy;
    logic               is_empty;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
  } rsp_t;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [31:0] value;
  } cmd_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic               cond;   // empty or holds a value above the operand
    logic               shift;  // this cell or one to its left matches a delete
  } link_t;

endpackage : sli_pkg
`default_nettype wire

### design/sorted_list_insert_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Sorted multiset of signed 32-bit values kept in a row of compare/shift
// cells; insert after equal values, delete one occurrence.
// ----------------------------------------------------------------------------
// The result beat appears in the cycle after the command is taken.
// Throughput: one command per cycle; busy stays low, the whole cell row updates
// together and the result is read from the registered cells.
// Reset clears every valid bit and the count; the store comes up empty.
// Results cannot be stalled: each beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sli_pkg::req_t req_i,
  output logic          result_valid_o,
  output sli_pkg::rsp_t result_o
);
  import sli_pkg::*;

  link_t            links [Capacity];
  cmd_t             cmd;
  logic             accept;
  logic             full;
  logic             found;
  logic [CntW-1:0]  count_q, count_d;
  status_e          status_q, status_d;
  logic             done_q;
  logic signed [31:0] largest;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = links[Capacity-1].valid;
  assign found  = links[Capacity-1].shift;

  always_comb begin
    cmd.ins   = accept && (req_i.mode == MODE_INSERT) && !full;
    cmd.del   = accept && (req_i.mode == MODE_DELETE);
    cmd.value = req_i.value;
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    link_t left_l, right_l;
    if (i == 0) begin : g_first
      assign left_l = '0;
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_l = '0;
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end
    sli_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .left_i (left_l),
      .right_i(right_l),
      .link_o (links[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      unique case (req_i.mode)
        MODE_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_DONE;
            count_d  = count_q + CntW'(1);
          end
        end
        MODE_DELETE: begin
          if (found) begin
            status_d = ST_DONE;
            count_d  = count_q - CntW'(1);
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        default: status_d = status_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_DONE;
      done_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
      done_q   <= accept;
    end
  end

  // Largest is the last valid cell; at most one cell sees its right neighbor empty.
  always_comb begin
    largest = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      if (links[i].valid && ((i == Capacity - 1) || !links[(i + 1) % Capacity].valid)) begin
        largest = largest | links[i].value;
      end
    end
  end

  always_comb begin
    result_valid_o     = done_q;
    result_o.status    = status_q;
    result_o.occupancy = 5'(count_q);
    result_o.is_empty  = (count_q == '0);
    result_o.smallest  = links[0].valid ? links[0].value : 32'sd0;
    result_o.largest   = largest;
  end

  // Count and the valid bits of the cell row agree.
  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !links[0].valid)
    else $error("count and first valid bit disagree");

  a_full_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(Capacity)) == links[Capacity-1].valid)
    else $error("count and last valid bit disagree");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("result beat missing after command");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.is_empty |-> ($signed(result_o.smallest) <= $signed(result_o.largest)))
    else $error("smallest above largest");

endmodule : sorted_list_insert_delete
`default_nettype wire

### design/sli_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted chain: holds a value and a valid bit, compares it
// with the broadcast operand and shifts right on insert, left on delete.
// ----------------------------------------------------------------------------
module sli_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sli_pkg::cmd_t  cmd_i,
  input  sli_pkg::link_t left_i,
  input  sli_pkg::link_t right_i,
  output sli_pkg::link_t link_o
);
  import sli_pkg::*;

  logic               valid_q, valid_d;
  logic signed [31:0] value_q, value_d;
  logic               gt;
  logic               hit;

  always_comb begin
    gt  = ($signed(value_q) > $signed(cmd_i.value));
    hit = (value_q == cmd_i.value);
    link_o.valid = valid_q;
    link_o.value = value_q;
    link_o.cond  = !valid_q || gt;
    link_o.shift = left_i.shift || (valid_q && hit);
  end

  always_comb begin
    priority if (cmd_i.ins && link_o.cond) begin
      // take the left neighbor when it moves right too, else land the operand here
      if (left_i.cond) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = cmd_i.value;
      end
    end else if (cmd_i.del && link_o.shift) begin
      // close the gap: pull from the right
      valid_d = right_i.valid;
      value_d = right_i.value;
    end else begin
      // hold
      valid_d = valid_q;
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule : sli_cell
`default_nettype wire
